[hw/rtl/pac_pkg.sv]
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants for the pure pursuit curvature pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pac_pkg;

    localparam int POS_W   = 24;
    localparam int DIFF_W  = 25;
    localparam int HEAD_W  = 16;
    localparam int TRIG_W  = 33;
    localparam int TRIG_FRAC = 30;
    localparam int PROD_W  = 58;
    localparam int MAG_W   = 59;
    localparam int DEN_W   = 50;
    localparam int CURV_W  = 32;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [TRIG_W-1:0] CORDIC_GAIN_Q30 = 33'd652032874;
    localparam logic [CURV_W-1:0] CURV_POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [CURV_W-1:0] CURV_NEG_MAG    = 32'h8000_0000;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [29:0] ATAN_TAB [ATAN_ENTRIES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Values that ride along with the CORDIC rotation.
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [1:0]               quad;
        logic                     coin;
    } side_t;

    // Numerator magnitude and denominator handed to the divider.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             coin;
    } ratio_t;

endpackage

`default_nettype wire

[hw/rtl/pac_cordic.sv]
// ----------------------------------------------------------------------------
// pac_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_cordic #(
    parameter int STAGES = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 en,
    input  wire                                 in_valid,
    input  wire signed [pac_pkg::TRIG_W-1:0]    in_z,
    input  pac_pkg::side_t                      in_side,
    output logic                                out_valid,
    output logic signed [pac_pkg::TRIG_W-1:0]   out_x,
    output logic signed [pac_pkg::TRIG_W-1:0]   out_y,
    output pac_pkg::side_t                      out_side
);

    logic                               valid_reg [STAGES+1];
    logic signed [pac_pkg::TRIG_W-1:0]  x_reg     [STAGES+1];
    logic signed [pac_pkg::TRIG_W-1:0]  y_reg     [STAGES+1];
    logic signed [pac_pkg::TRIG_W-1:0]  z_reg     [STAGES+1];
    pac_pkg::side_t                     side_reg  [STAGES+1];

    always_comb begin
        valid_reg[0] = in_valid;
        x_reg[0]     = $signed(pac_pkg::CORDIC_GAIN_Q30);
        y_reg[0]     = '0;
        z_reg[0]     = in_z;
        side_reg[0]  = in_side;
    end

    genvar i;
    generate
        for (i = 0; i < STAGES; i++) begin : g_stage
            logic signed [pac_pkg::TRIG_W-1:0] xs;
            logic signed [pac_pkg::TRIG_W-1:0] ys;
            logic signed [pac_pkg::TRIG_W-1:0] ang;
            logic signed [pac_pkg::TRIG_W-1:0] x_next, y_next, z_next;

            always_comb begin
                xs  = x_reg[i] >>> i;
                ys  = y_reg[i] >>> i;
                ang = $signed({3'b000, pac_pkg::ATAN_TAB[i]});
                if (!z_reg[i][pac_pkg::TRIG_W-1]) begin
                    x_next = x_reg[i] - ys;
                    y_next = y_reg[i] + xs;
                    z_next = z_reg[i] - ang;
                end else begin
                    x_next = x_reg[i] + ys;
                    y_next = y_reg[i] - xs;
                    z_next = z_reg[i] + ang;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i+1] <= 1'b0;
                end else if (en) begin
                    valid_reg[i+1] <= valid_reg[i];
                end
                if (en) begin
                    x_reg[i+1]    <= x_next;
                    y_reg[i+1]    <= y_next;
                    z_reg[i+1]    <= z_next;
                    side_reg[i+1] <= side_reg[i];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES];
    assign out_x     = x_reg[STAGES];
    assign out_y     = y_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

`default_nettype wire

[hw/rtl/pac_arith.sv]
// ----------------------------------------------------------------------------
// pac_arith
// Quadrant mapping, products, numerator and denominator, and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_arith (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 en,
    input  wire                                 in_valid,
    input  wire signed [pac_pkg::TRIG_W-1:0]    in_x,
    input  wire signed [pac_pkg::TRIG_W-1:0]    in_y,
    input  pac_pkg::side_t                      in_side,
    output logic                                out_valid,
    output pac_pkg::ratio_t                     out_ratio
);

    // Stage A: rotate the first-quadrant result into the heading's quadrant.
    logic                               a_valid_reg;
    logic signed [pac_pkg::TRIG_W-1:0]  sn_reg, cs_reg, sn_next, cs_next;
    pac_pkg::side_t                     a_side_reg;

    always_comb begin
        unique case (in_side.quad)
            2'd0: begin cs_next = in_x;  sn_next = in_y;  end
            2'd1: begin cs_next = -in_y; sn_next = in_x;  end
            2'd2: begin cs_next = -in_x; sn_next = -in_y; end
            default: begin cs_next = in_y; sn_next = -in_x; end
        endcase
    end

    // Stage B: the four products.
    logic                                b_valid_reg;
    logic signed [pac_pkg::PROD_W-1:0]   psx_reg, pcy_reg;
    logic signed [pac_pkg::DEN_W-1:0]    pxx_reg, pyy_reg;
    logic                                b_coin_reg;

    // Stage C: numerator and denominator.
    logic                                c_valid_reg;
    logic signed [pac_pkg::MAG_W-1:0]    num_reg;
    logic [pac_pkg::DEN_W-1:0]           den_reg;
    logic                                c_coin_reg;

    // Stage D: sign and magnitude.
    logic                                d_valid_reg;
    pac_pkg::ratio_t                     ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
        if (en) begin
            sn_reg     <= sn_next;
            cs_reg     <= cs_next;
            a_side_reg <= in_side;

            psx_reg    <= sn_reg * a_side_reg.dx;
            pcy_reg    <= cs_reg * a_side_reg.dy;
            pxx_reg    <= a_side_reg.dx * a_side_reg.dx;
            pyy_reg    <= a_side_reg.dy * a_side_reg.dy;
            b_coin_reg <= a_side_reg.coin;

            num_reg    <= pac_pkg::MAG_W'(psx_reg) - pac_pkg::MAG_W'(pcy_reg);
            den_reg    <= $unsigned(pxx_reg) + $unsigned(pyy_reg);
            c_coin_reg <= b_coin_reg;

            ratio_reg.neg  <= num_reg[pac_pkg::MAG_W-1];
            ratio_reg.mag  <= num_reg[pac_pkg::MAG_W-1] ? $unsigned(-num_reg)
                                                         : $unsigned(num_reg);
            ratio_reg.den  <= den_reg;
            ratio_reg.coin <= c_coin_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_ratio = ratio_reg;

endmodule

`default_nettype wire

[hw/rtl/pac_div.sv]
// ----------------------------------------------------------------------------
// pac_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_div #(
    parameter int SCALE_SHIFT = -5
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                en,
    input  wire                                in_valid,
    input  pac_pkg::ratio_t                    in_ratio,
    output logic                               out_valid,
    output logic [pac_pkg::CURV_W-1:0]         out_curv,
    output logic                               out_coin,
    output logic                               out_sat
);

    localparam int QB  = pac_pkg::CURV_W;
    localparam int KP  = (SCALE_SHIFT > 0) ? SCALE_SHIFT : 0;
    localparam int KN  = (SCALE_SHIFT < 0) ? -SCALE_SHIFT : 0;
    localparam int AW  = pac_pkg::MAG_W + KP;
    localparam int DW  = pac_pkg::DEN_W + KN + QB;
    localparam int CW  = ((AW > DW) ? AW : DW) + 1;

    logic           valid_reg [QB+1];
    logic [CW-1:0]  r_reg     [QB+1];
    logic [CW-1:0]  d_reg     [QB+1];
    logic [QB-1:0]  q_reg     [QB+1];
    logic           neg_reg   [QB+1];
    logic           coin_reg  [QB+1];
    logic           ovf_reg   [QB+1];

    logic [CW-1:0]  a_scaled, d_scaled;

    always_comb begin
        a_scaled = CW'(in_ratio.mag) << KP;
        d_scaled = CW'(in_ratio.den) << KN;
    end

    // Entry stage: a quotient of 2^32 or more is flagged here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            r_reg[0]    <= a_scaled;
            d_reg[0]    <= d_scaled;
            q_reg[0]    <= '0;
            neg_reg[0]  <= in_ratio.neg;
            coin_reg[0] <= in_ratio.coin;
            ovf_reg[0]  <= (a_scaled >> QB) >= d_scaled;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_bit
            logic [CW-1:0] cand;
            logic          ge;

            always_comb begin
                cand = d_reg[j] << (QB - 1 - j);
                ge   = r_reg[j] >= cand;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[j+1] <= 1'b0;
                end else if (en) begin
                    valid_reg[j+1] <= valid_reg[j];
                end
                if (en) begin
                    r_reg[j+1]    <= ge ? (r_reg[j] - cand) : r_reg[j];
                    d_reg[j+1]    <= d_reg[j];
                    q_reg[j+1]    <= {q_reg[j][QB-2:0], ge};
                    neg_reg[j+1]  <= neg_reg[j];
                    coin_reg[j+1] <= coin_reg[j];
                    ovf_reg[j+1]  <= ovf_reg[j];
                end
            end
        end
    endgenerate

    // Output stage: clip, apply sign, force zero for a coincident target.
    logic              o_valid_reg;
    logic [QB-1:0]     curv_reg, curv_next;
    logic              coin_o_reg, sat_reg, sat_next;
    logic [QB-1:0]     limit, clipped;

    always_comb begin
        limit    = neg_reg[QB] ? pac_pkg::CURV_NEG_MAG : pac_pkg::CURV_POS_MAX;
        sat_next = ovf_reg[QB] || (q_reg[QB] > limit);
        clipped  = sat_next ? limit : q_reg[QB];
        curv_next = neg_reg[QB] ? (~clipped + 1'b1) : clipped;
        if (coin_reg[QB]) begin
            curv_next = '0;
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= valid_reg[QB];
        end
        if (en) begin
            curv_reg   <= curv_next;
            sat_reg    <= sat_next;
            coin_o_reg <= coin_reg[QB];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_curv  = curv_reg;
    assign out_coin  = coin_o_reg;
    assign out_sat   = sat_reg;

endmodule

`default_nettype wire

[hw/rtl/pursuit_arc_curvature_unit.sv]
// Input register, then the CORDIC, arithmetic and divider stages, in that order.
// Throughput: one transaction per cycle; every stage is a register and the whole
// pipeline advances whenever the output register is empty or being taken.
// Reset: aresetn is synchronous and active low; it clears all valid bits, the
// data registers are not reset.
// ----------------------------------------------------------------------------
// pursuit_arc_curvature_unit
// Pure pursuit arc curvature: 2(sin h dx - cos h dy)/(dx^2 + dy^2), saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module pursuit_arc_curvature_unit #(
    parameter int POS_FRAC_BITS  = 8,
    parameter int CORDIC_STAGES  = 16,
    parameter int CURV_FRAC_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // robot_x[23:0], robot_y[47:24], robot_heading[63:48],
    // target_x[87:64], target_y[111:88]
    input  wire [111:0]  s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // curvature[31:0], coincident[32], saturated[33], zero pad[39:34]
    output logic [39:0]  m_tdata
);

    // Net power of two that scales |N| / den into the output format.
    localparam int SCALE_SHIFT = POS_FRAC_BITS + CURV_FRAC_BITS + 1 - pac_pkg::TRIG_FRAC;

    // The pipeline moves as one: it advances whenever the result register is
    // empty or its transaction completes this cycle, so a stall freezes every
    // stage in place and nothing is dropped or duplicated.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic signed [pac_pkg::POS_W-1:0] robot_x, robot_y, target_x, target_y;
    logic [pac_pkg::HEAD_W-1:0]       robot_heading;

    assign robot_x       = s_tdata[23:0];
    assign robot_y       = s_tdata[47:24];
    assign robot_heading = s_tdata[63:48];
    assign target_x      = s_tdata[87:64];
    assign target_y      = s_tdata[111:88];

    // Input stage: exact 25-bit differences, coincidence test, and the split
    // of the heading into quadrant and a residual angle in 2^-32 turn units.
    logic                              in_valid_reg;
    pac_pkg::side_t                    in_side_reg;
    logic signed [pac_pkg::TRIG_W-1:0] in_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
        if (en) begin
            in_side_reg.dx   <= pac_pkg::DIFF_W'(target_x) - pac_pkg::DIFF_W'(robot_x);
            in_side_reg.dy   <= pac_pkg::DIFF_W'(target_y) - pac_pkg::DIFF_W'(robot_y);
            in_side_reg.quad <= robot_heading[15:14];
            in_side_reg.coin <= (target_x == robot_x) && (target_y == robot_y);
            in_z_reg         <= $signed({3'b000, robot_heading[13:0], 16'h0000});
        end
    end

    logic                              cor_valid;
    logic signed [pac_pkg::TRIG_W-1:0] cor_x, cor_y;
    pac_pkg::side_t                    cor_side;

    pac_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_z      (in_z_reg),
        .in_side   (in_side_reg),
        .out_valid (cor_valid),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_side  (cor_side)
    );

    // Four stages: quadrant map, products, sum and difference, magnitude.
    logic            ar_valid;
    pac_pkg::ratio_t ar_ratio;

    pac_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cor_valid),
        .in_x      (cor_x),
        .in_y      (cor_y),
        .in_side   (cor_side),
        .out_valid (ar_valid),
        .out_ratio (ar_ratio)
    );

    // One entry stage, 32 quotient-bit stages, and the output register.
    logic                         dv_valid, dv_coin, dv_sat;
    logic [pac_pkg::CURV_W-1:0]   dv_curv;

    pac_div #(
        .SCALE_SHIFT (SCALE_SHIFT)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ar_valid),
        .in_ratio  (ar_ratio),
        .out_valid (dv_valid),
        .out_curv  (dv_curv),
        .out_coin  (dv_coin),
        .out_sat   (dv_sat)
    );

    assign m_tvalid = dv_valid;
    assign m_tdata  = {6'b000000, dv_sat, dv_coin, dv_curv};

endmodule

`default_nettype wire

[hw/rtl/pac_checker.sv]
// ----------------------------------------------------------------------------
// pac_checker
// Port-level checks for the curvature unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [39:0]  m_tdata
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A stalled output blocks the input side.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // A coincident target gives zero curvature and no saturation.
    a_coin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'h0 && !m_tdata[33])
        else $error("coincident result not zero");

    // A saturated result sits at one end of the range.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |->
            m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000)
        else $error("saturated result not at a limit");

endmodule

bind pursuit_arc_curvature_unit pac_checker u_pac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pursuit_arc_curvature_unit. Random and directed
// pose/target pairs are streamed in. A bit-exact curvature predictor,
// including its own CORDIC, scores every result in order.
// ----------------------------------------------------------------------------

// Scoreboard: predicts the curvature for each accepted pose/target pair and
// compares the results that leave the block, in order.
class curvature_board;
    typedef struct {
        logic [31:0] curvature;
        logic        coincident;
        logic        saturated;
    } arc_t;

    arc_t pending[$];
    int   errors;
    int   checked;
    int   n_coin;
    int   n_on_line;

    function new();
        errors    = 0;
        checked   = 0;
        n_coin    = 0;
        n_on_line = 0;
    endfunction

    // Predict one arc from a packed input transaction.
    function void note(logic [111:0] d);
        longint rx, ry, tx, ty, dx, dy, cx, cy, cz, xs, ys, sn, cs, num;
        longint unsigned mag, den, q, r, limit;
        int k;
        logic [15:0] hd;
        bit neg;
        arc_t a;
        rx = $signed(d[23:0]);
        ry = $signed(d[47:24]);
        hd = d[63:48];
        tx = $signed(d[87:64]);
        ty = $signed(d[111:88]);
        dx = tx - rx;
        dy = ty - ry;
        if (dx == 0 && dy == 0) begin
            a.curvature = '0;
            a.coincident = 1'b1;
            a.saturated = 1'b0;
            n_coin++;
            pending.push_back(a);
            return;
        end
        // Rotation-mode CORDIC on the residual angle, in 2^-32 turn units.
        cx = longint'(pac_pkg::CORDIC_GAIN_Q30);
        cy = 0;
        cz = longint'(hd[13:0]) << 16;
        for (int i = 0; i < 16; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0) begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - longint'(pac_pkg::ATAN_TAB[i]);
            end else begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + longint'(pac_pkg::ATAN_TAB[i]);
            end
        end
        // Quadrant folding back to the full heading.
        case (hd[15:14])
            2'd0: begin cs = cx;  sn = cy;  end
            2'd1: begin cs = -cy; sn = cx;  end
            2'd2: begin cs = -cx; sn = -cy; end
            default: begin cs = cy; sn = -cx; end
        endcase
        num = sn * dx - cs * dy;
        if (num == 0) n_on_line++;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        den = dx * dx + dy * dy;
        k = 8 + 16 + 1 - pac_pkg::TRIG_FRAC;
        q = mag / den;
        r = mag % den;
        if (k < 0) begin
            q = q >> (-k);
        end else begin
            for (int j = 0; j < k; j++) begin
                if (q > (64'd1 << 32)) break;
                q = q << 1;
                r = r << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
        end
        limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        a.saturated = 1'b0;
        if (q > limit) begin
            q = limit;
            a.saturated = 1'b1;
        end
        a.curvature = neg ? 32'(64'd0 - q) : 32'(q);
        a.coincident = 1'b0;
        pending.push_back(a);
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check(logic [39:0] d);
        arc_t a;
        if (pending.size() == 0) begin
            $error("result with no prediction waiting: %h", d);
            errors++;
            return;
        end
        a = pending.pop_front();
        checked++;
        if (d[31:0] !== a.curvature) begin
            $error("curvature: expected %0d, actual %0d",
                   $signed(a.curvature), $signed(d[31:0]));
            errors++;
        end
        if (d[32] !== a.coincident) begin
            $error("coincident: expected %b, actual %b", a.coincident, d[32]);
            errors++;
        end
        if (d[33] !== a.saturated) begin
            $error("saturated: expected %b, actual %b", a.saturated, d[33]);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    wire          s_tready;
    logic [111:0] s_tdata;
    wire          m_tvalid;
    logic         m_tready;
    wire  [39:0]  m_tdata;

    // Idling on both sides stops for the final stretch of the run.
    bit quiet;
    curvature_board board;

    pursuit_arc_curvature_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Monitors sample at the edge, before the driver updates take effect.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check(m_tdata);
    end

    // Result side back-pressure: random stall bursts, none once quiet.
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
        end
    end

    // Send one pose/target pair, with an optional idle burst before it.
    task automatic send_pair(input logic [23:0] rx, input logic [23:0] ry,
                             input logic [15:0] hd, input logic [23:0] tx,
                             input logic [23:0] ty);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ty, tx, hd, ry, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Heading biased toward quadrant boundaries now and then.
    function automatic logic [15:0] pick_heading();
        logic [15:0] h;
        h = 16'($urandom);
        if ($urandom_range(0, 5) == 0)
            h = {h[15:14], 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
        return h;
    endfunction

    initial begin
        logic [23:0] rx, ry, tx, ty;
        int sel;
        board    = new();
        quiet    = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: target on robot, field extremes, quadrant boundaries,
        // unit-step distances and target straight along the heading.
        send_pair(24'd0, 24'd0, 16'd0, 24'd0, 24'd0);
        send_pair(24'h7FFFFF, 24'h800000, 16'hFFFF, 24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h800000, 16'd0, 24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 16'd32768, 24'h800000, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF, 16'd16384, 24'h7FFFFF, 24'h800000);
        send_pair(24'd0, 24'd0, 16'd16384, 24'd1, 24'd0);
        send_pair(24'd0, 24'd0, 16'd49152, 24'd0, 24'd1);
        send_pair(24'd0, 24'd0, 16'd32768, 24'hFFFFFF, 24'd0);
        send_pair(24'd0, 24'd0, 16'd16383, 24'd0, 24'hFFFFFF);
        send_pair(24'd0, 24'd0, 16'd0, 24'd1000, 24'd0);
        send_pair(24'd0, 24'd0, 16'd16384, 24'd0, 24'd1000);
        send_pair(24'd5, 24'd5, 16'd32768, 24'd5 - 24'd700, 24'd5);
        send_pair(24'd0, 24'd0, 16'd8192, 24'd500, 24'd500);
        send_pair(24'd0, 24'd0, 16'd40960, 24'hFFFE0C, 24'hFFFE0C);
        send_pair(24'h123456, 24'hABCDEF, 16'h5A5A, 24'h123456, 24'hABCDEF);
        send_pair(24'h800000, 24'h800000, 16'd65535, 24'h800001, 24'h800000);

        for (int n = 0; n < 1700; n++) begin
            if (n == 1500) quiet = 1'b1;
            rx  = 24'($urandom);
            ry  = 24'($urandom);
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                tx = rx;
                ty = ry;
            end else if (sel < 7) begin
                tx = rx + 24'($urandom_range(0, 4000)) - 24'd2000;
                ty = ry + 24'($urandom_range(0, 4000)) - 24'd2000;
            end else begin
                tx = 24'($urandom);
                ty = 24'($urandom);
            end
            send_pair(rx, ry, pick_heading(), tx, ty);
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        $display("Checked %0d curvature results: %0d with target on robot, %0d %s",
                 board.checked, board.n_coin, board.n_on_line, "on the heading line.");
        if (board.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/pac_pkg.sv
hw/rtl/pac_cordic.sv
hw/rtl/pac_arith.sv
hw/rtl/pac_div.sv
hw/rtl/pursuit_arc_curvature_unit.sv
hw/rtl/pac_checker.sv
tb/testbench.sv
